// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque with key search.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OPCODE_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DEL_HEAD = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_TAIL = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

// File: rtl/circular_deque_with_search.sv
// ----------------------------------------------------------------------------
// circular_deque_with_search
// Bounded ring deque of 32-bit words with head/tail insert, head/tail delete
// and a key search that walks the stored entries with one comparator.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Inserts, deletes,
// unused opcodes and a search of an empty store report in the next cycle; a new
// operation may be started in that same cycle. A search reads one ring entry
// per cycle through the registered read port of the entry memory and checks
// it with a single comparator; it reports when a word matches or after the last
// stored entry is checked, with busy high meanwhile. Each result is shown for one
// cycle with done high and cannot be held off. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module circular_deque_with_search #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic        [cdq_pkg::OPCODE_W-1:0] opcode,
  input  logic signed [cdq_pkg::VALUE_W-1:0]  value,
  output logic                                done,
  output logic        [cdq_pkg::STATUS_W-1:0] status,
  output logic                                found,
  output logic        [cdq_pkg::OCC_W-1:0]    occupancy
);
  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;

  state_t             state;
  logic [IW-1:0]      front;
  logic [CW-1:0]      count;
  logic [IW-1:0]      scan_pos;
  logic [CW-1:0]      scan_idx;
  logic               rd_pend;
  logic [VALUE_W-1:0] key;

  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic [IW-1:0]      head_prev;
  logic [IW-1:0]      head_next;
  logic [IW:0]        tail_sum;
  logic [IW-1:0]      tail_pos;
  logic [IW-1:0]      scan_pos_next;
  logic               issuing;
  logic               hit;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  assign head_prev     = (front == '0) ? LAST_POS : front - IW'(1);
  assign head_next     = (front == LAST_POS) ? '0 : front + IW'(1);
  assign tail_sum      = {1'b0, front} + (IW + 1)'(count);
  assign tail_pos      = (tail_sum >= DEPTH_X) ? IW'(tail_sum - DEPTH_X) : tail_sum[IW-1:0];
  assign scan_pos_next = (scan_pos == LAST_POS) ? '0 : scan_pos + IW'(1);
  assign issuing       = (scan_idx != count);
  assign hit           = rd_pend && (rd_data == key);

  assign wr_en   = accept && !is_full &&
                   ((opcode == OP_INS_HEAD) || (opcode == OP_INS_TAIL));
  assign wr_addr = (opcode == OP_INS_HEAD) ? head_prev : tail_pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    rd_data <= mem[scan_pos];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      scan_pos  <= '0;
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
      status    <= ST_DONE;
      found     <= 1'b0;
      occupancy <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            found     <= 1'b0;
            status    <= ST_DONE;
            occupancy <= OCC_W'(count);
            done      <= 1'b1;
            case (opcode)
              OP_INS_HEAD: begin
                if (is_full) begin
                  status <= ST_FULL;
                end else begin
                  front     <= head_prev;
                  count     <= count + CW'(1);
                  occupancy <= OCC_W'(count + CW'(1));
                end
              end
              OP_INS_TAIL: begin
                if (is_full) begin
                  status <= ST_FULL;
                end else begin
                  count     <= count + CW'(1);
                  occupancy <= OCC_W'(count + CW'(1));
                end
              end
              OP_DEL_HEAD: begin
                if (is_empty) begin
                  status <= ST_EMPTY;
                end else begin
                  front     <= head_next;
                  count     <= count - CW'(1);
                  occupancy <= OCC_W'(count - CW'(1));
                end
              end
              OP_DEL_TAIL: begin
                if (is_empty) begin
                  status <= ST_EMPTY;
                end else begin
                  count     <= count - CW'(1);
                  occupancy <= OCC_W'(count - CW'(1));
                end
              end
              OP_SEARCH: begin
                if (is_empty) begin
                  status <= ST_EMPTY;
                end else begin
                  done     <= 1'b0;
                  scan_pos <= front;
                  scan_idx <= '0;
                  state    <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue one read per cycle, compare the word read last cycle
          if (issuing) begin
            scan_pos <= scan_pos_next;
            scan_idx <= scan_idx + CW'(1);
          end
          rd_pend <= issuing;
          if (hit || (!issuing && !rd_pend)) begin
            rd_pend   <= 1'b0;
            done      <= 1'b1;
            status    <= ST_DONE;
            found     <= hit;
            occupancy <= OCC_W'(count);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted operation neither reported nor in progress");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_DONE))
    else $error("hit reported with error status");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SCAN))
    else $error("read pending outside scan");
`endif

endmodule
